### hdl/fpfa_pkg.sv
// shared constants and types for the fixed partition fit allocator
`default_nettype none

package fpfa_pkg;

  // fixed field widths
  localparam int POLICY_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int SLOT_W    = 4;
  localparam int AMOUNT_W  = 16;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // placement policies
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  // request kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 1'b1;

  // control from sequencer to pick unit
  typedef struct packed {
    logic clear;
    logic eval;
  } pick_cmd_t;

endpackage

`default_nettype wire

### hdl/fpfa_mem.sv
// free size memory with one write port, one registered read port and per-entry valid bits
`default_nettype none

module fpfa_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] ram [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] ram_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
    if (re) begin
      ram_q <= ram[raddr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        vld_q <= valid[raddr];
      end
    end
  end

  assign rdata = vld_q ? ram_q : '0;

endmodule

`default_nettype wire

### hdl/fpfa_pick.sv
// running pick of the fitting entry under the selected policy
`default_nettype none

module fpfa_pick #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire fpfa_pkg::pick_cmd_t                 cmd,
  input  wire logic [fpfa_pkg::POLICY_W-1:0]       policy,
  input  wire logic [fpfa_pkg::AMOUNT_W-1:0]       amount,
  input  wire logic [$clog2(DEPTH)-1:0]            idx,
  input  wire logic [WIDTH-1:0]                    data,
  output logic                                     found,
  output logic      [$clog2(DEPTH)-1:0]            pick_idx,
  output logic      [WIDTH-1:0]                    pick_size
);
  import fpfa_pkg::*;

  localparam int AW = (WIDTH > AMOUNT_W) ? WIDTH : AMOUNT_W;

  logic fits;
  logic takes_over;
  logic take;

  assign fits = AW'(data) >= AW'(amount);

  always_comb begin
    takes_over = 1'b0;
    unique case (policy)
      POLICY_BEST:  takes_over = data < pick_size;
      POLICY_WORST: takes_over = data > pick_size;
      default:      takes_over = 1'b0;
    endcase
  end

  // ties keep the lower index since only strict improvements replace
  assign take = cmd.eval && fits && (!found || takes_over);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx  <= idx;
      pick_size <= data;
    end
  end

endmodule

`default_nettype wire

### hdl/fixed_partition_fit_allocator.sv
// top level of the fixed partition fit allocator: sequencer, config registers, output register
// sequence: a load goes straight to the finish state and its result is registered there; an
//   allocate first scans count entries (partition_count clamped to PARTITIONS), then finishes
// throughput: one request at a time, set by the single read port of the free size
//   memory, which is scanned one entry per cycle; the next request is accepted once the
//   finish state has registered the result, and that state waits while out_stall holds
// reset: synchronous, clears policy to first fit, count to 16 and all sizes to zero
`default_nettype none

module fixed_partition_fit_allocator #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpfa_pkg::CFG_W-1:0]         cfg_data,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               action,
  input  wire logic [fpfa_pkg::SLOT_W-1:0]        slot,
  input  wire logic [fpfa_pkg::AMOUNT_W-1:0]      amount,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    granted,
  output logic      [fpfa_pkg::SLOT_W-1:0]        chosen_slot
);
  import fpfa_pkg::*;

  localparam int IDX_W = $clog2(PARTITIONS);
  // counter must hold both the register value and the table depth
  localparam int CNT_A = $clog2(PARTITIONS + 1);
  localparam int CW    = (CNT_A > COUNT_W) ? CNT_A : COUNT_W;
  localparam int AW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [POLICY_W-1:0] policy;
  logic [COUNT_W-1:0]  partition_count;

  // latched request
  logic                action_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [CW-1:0]       count_q;

  // scan pipeline: read issued one cycle, evaluated the next
  logic [CW-1:0]       rd_idx;
  logic                eval_valid;
  logic [IDX_W-1:0]    eval_idx;

  logic                 accept;
  logic                 rd_en;
  logic                 out_free;
  logic                 finish_fire;
  logic                 load_ok;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [SIZE_BITS-1:0] mem_rdata;
  logic [CW-1:0]        count_clamped;

  pick_cmd_t            pick_cmd;
  logic                 found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_size;

  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign finish_fire = (state == ST_FINISH) && out_free;
  assign rd_en       = (state == ST_SCAN) && (rd_idx < count_q);

  // a count above the table depth searches the whole table
  assign count_clamped = (CW'(partition_count) > CW'(PARTITIONS)) ?
                         CW'(PARTITIONS) : CW'(partition_count);

  // loads to slots past the table are dropped without a grant
  assign load_ok = (action_q == ACT_LOAD) && (32'(slot_q) < PARTITIONS);

  // the single write happens in the finish cycle; the next request cannot read
  // before the following cycle, so no forwarding path is needed
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick_idx;
    mem_wdata = SIZE_BITS'(AW'(pick_size) - AW'(amount_q));
    if (action_q == ACT_LOAD) begin
      mem_waddr = IDX_W'(slot_q);
      mem_wdata = SIZE_BITS'(amount_q);
      mem_we    = finish_fire && load_ok;
    end else begin
      mem_we    = finish_fire && found;
    end
  end

  assign pick_cmd.clear = accept;
  assign pick_cmd.eval  = eval_valid;

  fpfa_mem #(
    .DEPTH (PARTITIONS),
    .WIDTH (SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  fpfa_pick #(
    .DEPTH (PARTITIONS),
    .WIDTH (SIZE_BITS)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .cmd       (pick_cmd),
    .policy    (policy),
    .amount    (amount_q),
    .idx       (eval_idx),
    .data      (mem_rdata),
    .found     (found),
    .pick_idx  (pick_idx),
    .pick_size (pick_size)
  );

  // configuration registers, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      policy          <= POLICY_FIRST;
      partition_count <= COUNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy          <= cfg_data[POLICY_W-1:0];
        REG_COUNT:  partition_count <= cfg_data;
        default:    policy          <= policy;
      endcase
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q <= action;
      slot_q   <= slot;
      amount_q <= amount;
      count_q  <= count_clamped;
    end
    eval_idx <= rd_idx[IDX_W-1:0];
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_idx      <= '0;
      eval_valid  <= 1'b0;
      out_valid   <= 1'b0;
      granted     <= 1'b0;
      chosen_slot <= '0;
    end else begin
      eval_valid <= rd_en;
      if (out_valid && !out_stall && !finish_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rd_idx <= '0;
            state  <= (action == ACT_ALLOC) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            rd_idx <= rd_idx + CW'(1);
          end else if (!eval_valid) begin
            // last fetched entry has been judged
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (action_q == ACT_LOAD) begin
              granted     <= load_ok;
              chosen_slot <= load_ok ? slot_q : '0;
            end else begin
              granted     <= found;
              chosen_slot <= found ? SLOT_W'(pick_idx) : '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an accepted request raises in_stall in the following cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted back to back");

  // a refused result never names a slot
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (chosen_slot == '0))
    else $error("refused result carries a slot");

  // a granted allocation always fits its picked entry
  a_pick_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && action_q == ACT_ALLOC && found) |->
    (AW'(pick_size) >= AW'(amount_q)))
    else $error("picked entry smaller than request");

  // the scan never reads past the clamped count
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (rd_idx <= count_q))
    else $error("scan index past count");

endmodule

`default_nettype wire

### bench/tb_fixed_partition_fit_allocator.sv
// self-checking testbench for the fixed partition fit allocator
module tb_fixed_partition_fit_allocator;
  import fpfa_pkg::*;

  // table geometry used by both the dut and the prediction
  localparam int PARTS    = 16;
  localparam int SZ_BITS  = 16;
  // the longest correct gap between two handshakes is an allocate at full count
  // plus random stalls, so this only trips on a hang
  localparam int HANG_LIMIT = 3000;
  // room after the last drain for any straggler, even an allocate at count 16
  localparam int TAIL_CYCLES = 40;

  // one request as the sender sees it
  typedef struct {
    logic                act;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amt;
  } alloc_req_t;

  // one result as the receiver sees it
  typedef struct {
    logic              ok;
    logic [SLOT_W-1:0] pick;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every dut input starts at a known value
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_POLICY;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 action    = ACT_LOAD;
  logic [SLOT_W-1:0]    slot      = '0;
  logic [AMOUNT_W-1:0]  amount    = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 granted;
  logic [SLOT_W-1:0]    chosen_slot;

  // requests waiting to be sent and results waiting to be seen
  alloc_req_t req_q[$];
  grant_t     grant_q[$];
  grant_t     due;

  // shadow copy of the allocator: free sizes and the two registers
  logic [SZ_BITS-1:0]  part_free [PARTS];
  logic [POLICY_W-1:0] pol_now = POLICY_FIRST;
  logic [COUNT_W-1:0]  cnt_now = 5'd16;

  int  n_issued    = 0;
  int  n_errors    = 0;
  int  quiet_cycles = 0;
  // when set neither side idles
  bit  calm = 1'b0;

  fixed_partition_fit_allocator #(
    .PARTITIONS(PARTS),
    .SIZE_BITS (SZ_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .slot       (slot),
    .amount     (amount),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .granted    (granted),
    .chosen_slot(chosen_slot)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // one line per mismatch, counted for the final verdict
  task automatic flag_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // apply one request to the shadow table and return the result it must give
  function automatic grant_t place_request(input alloc_req_t r);
    grant_t g;
    int     lim;
    bit     hit;
    int     at;
    bit     first_mode;
    g.ok       = 1'b0;
    g.pick     = '0;
    hit        = 1'b0;
    at         = 0;
    first_mode = (pol_now != POLICY_BEST) && (pol_now != POLICY_WORST);
    if (r.act == ACT_LOAD) begin
      // every 4-bit slot is inside a 16-entry table, so a load always lands
      part_free[r.slot] = r.amt;
      g.ok   = 1'b1;
      g.pick = r.slot;
    end else begin
      // count above the table size is clamped, zero searches nothing
      lim = (cnt_now > PARTS) ? PARTS : cnt_now;
      for (int j = 0; j < lim; j++) begin
        // first fit stops looking at the first entry that fits
        if (part_free[j] >= r.amt && !(hit && first_mode)) begin
          if (!hit) begin
            hit = 1'b1;
            at  = j;
          end else if (pol_now == POLICY_BEST && part_free[j] < part_free[at]) begin
            at = j;
          end else if (pol_now == POLICY_WORST && part_free[j] > part_free[at]) begin
            at = j;
          end
        end
      end
      if (hit) begin
        // a zero request leaves the chosen entry as it was
        part_free[at] = part_free[at] - r.amt;
        g.ok   = 1'b1;
        g.pick = at[SLOT_W-1:0];
      end
    end
    return g;
  endfunction

  function automatic void add_req(input logic a, input logic [SLOT_W-1:0] s,
                                  input logic [AMOUNT_W-1:0] v);
    alloc_req_t r;
    r.act  = a;
    r.slot = s;
    r.amt  = v;
    req_q.push_back(r);
    n_issued++;
  endfunction

  // block until nothing is queued, in flight or still owed by the dut;
  // sampled on the falling edge so the clocked blocks have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || in_valid || grant_q.size() != 0);
  endtask

  // register write while the block is idle; the shadow copy follows at once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_POLICY) pol_now = val[POLICY_W-1:0];
    else cnt_now = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // request driver: holds a stalled request, otherwise idles at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        grant_q.push_back(place_request(req_q.pop_front()));
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && !(!calm && $urandom_range(99) < 34)) begin
          in_valid <= 1'b1;
          action   <= req_q[0].act;
          slot     <= req_q[0].slot;
          amount   <= req_q[0].amt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          flag_mismatch("result with nothing expected, granted", int'(granted), 0);
        end else begin
          due = grant_q.pop_front();
          if (granted !== due.ok) flag_mismatch("granted", int'(granted), int'(due.ok));
          if (chosen_slot !== due.pick) begin
            flag_mismatch("chosen_slot", int'(chosen_slot), int'(due.pick));
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 34);
    end
  end

  // hang detector: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int                 ph;
    int                 i;
    int                 span;
    int                 n_loads;
    int                 n_allocs;
    logic [CFG_W-1:0]   wdata;
    logic [AMOUNT_W-1:0] last_amt;

    for (int j = 0; j < PARTS; j++) part_free[j] = '0;
    last_amt = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset registers: first fit over all 16 entries
    add_req(ACT_ALLOC, 4'd0, 16'd0);        // zero request fits an empty entry
    add_req(ACT_ALLOC, 4'd0, 16'd1);        // nothing fits an all-zero table
    add_req(ACT_ALLOC, 4'd15, 16'hffff);
    add_req(ACT_LOAD,  4'd0, 16'hffff);
    add_req(ACT_LOAD,  4'd15, 16'hffff);
    add_req(ACT_LOAD,  4'd7, 16'h00aa);
    add_req(ACT_LOAD,  4'd4, 16'd100);
    add_req(ACT_LOAD,  4'd9, 16'd100);      // tie with slot 4
    add_req(ACT_ALLOC, 4'd0, 16'hffff);     // takes a whole entry
    add_req(ACT_ALLOC, 4'd0, 16'hffff);
    wait_drained();
    // best fit, tie between equal sizes goes to the lower index
    write_reg(REG_POLICY, {3'b000, POLICY_BEST});
    add_req(ACT_ALLOC, 4'd0, 16'd60);
    add_req(ACT_ALLOC, 4'd0, 16'd60);
    add_req(ACT_ALLOC, 4'd0, 16'd0);
    wait_drained();
    // worst fit
    write_reg(REG_POLICY, {3'b000, POLICY_WORST});
    add_req(ACT_ALLOC, 4'd0, 16'd10);
    add_req(ACT_LOAD,  4'd2, 16'h5555);
    add_req(ACT_LOAD,  4'd3, 16'h5555);
    add_req(ACT_ALLOC, 4'd0, 16'd1);
    wait_drained();
    // unused policy code acts as first fit; upper data bits set
    write_reg(REG_POLICY, 5'b11111);
    add_req(ACT_ALLOC, 4'd0, 16'd1);
    wait_drained();
    // zero count grants nothing, even a zero request
    write_reg(REG_COUNT, 5'd0);
    add_req(ACT_ALLOC, 4'd0, 16'd0);
    wait_drained();
    // count above table size is clamped
    write_reg(REG_COUNT, 5'd31);
    add_req(ACT_LOAD,  4'd15, 16'h1234);
    add_req(ACT_ALLOC, 4'd0, 16'h1234);
    wait_drained();
    // single partition in use
    write_reg(REG_COUNT, 5'd1);
    add_req(ACT_ALLOC, 4'd0, 16'd0);
    add_req(ACT_ALLOC, 4'd0, 16'hffff);
    wait_drained();

    // random phases: new registers, fill the table, then mostly allocate
    ph = 0;
    while (n_issued < 850) begin
      // a run of phases with no idling on either side
      calm = (ph >= 4 && ph < 9);
      wdata = CFG_W'($urandom);
      wdata[POLICY_W-1:0] = POLICY_W'($urandom_range(0, 3));
      write_reg(REG_POLICY, wdata);
      case ($urandom_range(0, 9))
        0:       wdata = 5'd0;
        1:       wdata = 5'd16;
        2:       wdata = CFG_W'($urandom_range(17, 31));
        3:       wdata = 5'd1;
        default: wdata = CFG_W'($urandom_range(2, 16));
      endcase
      write_reg(REG_COUNT, wdata);
      // narrow value spans give many fits and ties, the full span hits every bit
      case ($urandom_range(0, 3))
        0:       span = 63;
        1:       span = 1023;
        2:       span = 4095;
        default: span = 65535;
      endcase
      n_loads = $urandom_range(3, 16);
      for (i = 0; i < n_loads; i++) begin
        // reuse the last size now and then to make ties
        if ($urandom_range(0, 3) != 0) last_amt = AMOUNT_W'($urandom_range(0, span));
        add_req(ACT_LOAD, SLOT_W'($urandom_range(0, 15)), last_amt);
      end
      n_allocs = $urandom_range(12, 32);
      for (i = 0; i < n_allocs; i++) begin
        // sender holds off until every result is back
        if (ph % 5 == 2 && i == n_allocs / 2) wait_drained();
        case ($urandom_range(0, 19))
          0:       add_req(ACT_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'd0);
          1:       add_req(ACT_ALLOC, SLOT_W'($urandom_range(0, 15)), 16'hffff);
          2, 3:    add_req(1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 15)),
                           AMOUNT_W'($urandom_range(0, 65535)));
          4, 5:    add_req(ACT_LOAD, SLOT_W'($urandom_range(0, 15)),
                           AMOUNT_W'($urandom_range(0, span)));
          default: add_req(ACT_ALLOC, SLOT_W'($urandom_range(0, 15)),
                           AMOUNT_W'($urandom_range(0, span / 3)));
        endcase
      end
      wait_drained();
      ph++;
    end

    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (grant_q.size() != 0) flag_mismatch("results never seen, count", 0, grant_q.size());
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
